// File: rtl/bdhe_pkg.sv
// Shared constants, codes and types for the button debouncer with hold and edge windows.
// No dependencies; used by every module in rtl/.
package bdhe_pkg;

    localparam int BUTTON_COUNT = 3;   // number of buttons handled (only the first PIN_W get a pin and mask bit)
    localparam int PIN_W        = 3;   // width of the pin and mask fields
    localparam int IDX_W        = 8;   // width of button_index
    localparam int KIND_W       = 2;
    localparam int MODE_W       = 2;
    localparam int DEB_W        = 8;
    localparam int HOLD_W       = 16;
    localparam int WIN_W        = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int S_TDATA_W    = 16;  // pin_levels + button_index, byte padded
    localparam int M_TDATA_W    = 16;  // three masks + edge_seen, byte padded

    // item kinds
    localparam logic [KIND_W-1:0] KIND_TICK      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UPDATE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ_RISE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ_FALL = 2'd3;

    // button modes
    localparam logic [MODE_W-1:0] MODE_RELEASED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PRESSED  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HELD     = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 2'd2;

    // configuration register reset values
    localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 8'd50;
    localparam logic [HOLD_W-1:0] HOLD_RST     = 16'd1000;
    localparam logic [WIN_W-1:0]  WINDOW_RST   = 8'd40;

    typedef struct packed {
        logic [DEB_W-1:0]  debounce_ms;
        logic [HOLD_W-1:0] hold_ms;
        logic [WIN_W-1:0]  edge_window_ms;
    } cfg_t;

    typedef struct packed {
        logic tick;
        logic update;
        logic pin_high;
        logic clr_rise;
        logic clr_fall;
    } button_ctrl_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode_next;
        logic              rise_open;
        logic              fall_open;
    } button_stat_t;

endpackage

// File: rtl/bdhe_cfg.sv
// Configuration register file: debounce, hold and edge window times.
// Depends on bdhe_pkg.
module bdhe_cfg
    import bdhe_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [DEB_W-1:0]  debounce_reg;
    logic [HOLD_W-1:0] hold_reg;
    logic [WIN_W-1:0]  window_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RST;
            hold_reg     <= HOLD_RST;
            window_reg   <= WINDOW_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_DEBOUNCE: debounce_reg <= cfg_data[DEB_W-1:0];
                REG_HOLD:     hold_reg     <= cfg_data[HOLD_W-1:0];
                REG_WINDOW:   window_reg   <= cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.debounce_ms    = debounce_reg;
    assign cfg.hold_ms        = hold_reg;
    assign cfg.edge_window_ms = window_reg;

endmodule

// File: rtl/bdhe_button.sv
// One button: mode register, four countdown timers and the mode rule.
// Depends on bdhe_pkg.
module bdhe_button
    import bdhe_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  cfg_t         cfg,
    input  button_ctrl_t ctrl,
    output button_stat_t stat
);

    logic [MODE_W-1:0] mode_reg,     mode_next;
    logic [DEB_W-1:0]  debounce_reg, debounce_next;
    logic [HOLD_W-1:0] hold_reg,     hold_next;
    logic [WIN_W-1:0]  rise_reg,     rise_next;
    logic [WIN_W-1:0]  fall_reg,     fall_next;

    always_comb begin
        mode_next     = mode_reg;
        debounce_next = debounce_reg;
        hold_next     = hold_reg;
        rise_next     = rise_reg;
        fall_next     = fall_reg;
        if (ctrl.tick) begin
            if (debounce_reg != '0) debounce_next = debounce_reg - 1'b1;
            if (hold_reg != '0)     hold_next     = hold_reg - 1'b1;
            if (rise_reg != '0)     rise_next     = rise_reg - 1'b1;
            if (fall_reg != '0)     fall_next     = fall_reg - 1'b1;
        end else if (ctrl.update) begin
            // a reload to zero debounce lets the mode change in the same update
            unique case (mode_reg)
                MODE_PRESSED: begin
                    if (!ctrl.pin_high) begin
                        debounce_next = cfg.debounce_ms;
                        if (hold_reg == '0) mode_next = MODE_HELD;
                    end
                    if (debounce_next == '0) begin
                        fall_next = cfg.edge_window_ms;
                        mode_next = MODE_RELEASED;
                    end
                end
                MODE_HELD: begin
                    if (!ctrl.pin_high) debounce_next = cfg.debounce_ms;
                    if (debounce_next == '0) begin
                        fall_next = cfg.edge_window_ms;
                        mode_next = MODE_RELEASED;
                    end
                end
                default: begin
                    // released, and the unused code behaves the same
                    if (ctrl.pin_high) debounce_next = cfg.debounce_ms;
                    if (debounce_next == '0) begin
                        rise_next = cfg.edge_window_ms;
                        hold_next = cfg.hold_ms;
                        mode_next = MODE_PRESSED;
                    end
                end
            endcase
        end else begin
            if (ctrl.clr_rise) rise_next = '0;
            if (ctrl.clr_fall) fall_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_RELEASED;
            debounce_reg <= '0;
            hold_reg     <= '0;
            rise_reg     <= '0;
            fall_reg     <= '0;
        end else begin
            mode_reg     <= mode_next;
            debounce_reg <= debounce_next;
            hold_reg     <= hold_next;
            rise_reg     <= rise_next;
            fall_reg     <= fall_next;
        end
    end

    assign stat.mode_next = mode_next;
    assign stat.rise_open = (rise_reg != '0);
    assign stat.fall_open = (fall_reg != '0);

endmodule

// File: rtl/button_debounce_hold_edge.sv
// Top level of the button debouncer: item stream in, mask/edge result stream out.
// Depends on bdhe_pkg, bdhe_cfg and bdhe_button.
//
// Usage:
//   s_ channel carries items: s_tuser is the kind (tick, update with pins,
//   read rising edge, read falling edge); s_tdata carries the pin levels and
//   the button index of a read. Every item yields exactly one result on the
//   m_ channel: released, pressed and held masks as they stand after the item,
//   plus edge_seen for reads (window was open; the window is then closed).
//   cfg_ channel writes debounce, hold and edge window times; it is always
//   ready and should be used only while no item is in flight.
// Result timing and flow:
//   A result is registered and is valid in the cycle after its item transfer. All
//   buttons update in parallel on that transfer, so one item per cycle is sustained
//   while m_tready stays high. The output register frees in the cycle it is taken,
//   so s_tready stays high while the receiver keeps m_tready high.
// Reset and stalls:
//   aresetn (synchronous, active low) releases every button, clears all timers
//   and loads the default times. While m_tvalid is high and m_tready low, the
//   result holds and s_tready is low.
module button_debounce_hold_edge
    import bdhe_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata: pin_levels[2:0], button_index[10:3], zero [15:11]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser: kind[1:0]
    input  logic [KIND_W-1:0]     s_tuser,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // m_tdata: released_mask[2:0], pressed_mask[5:3], held_mask[8:6],
    //          edge_seen[9], zero [15:10]
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t                            cfg;
    button_ctrl_t [BUTTON_COUNT-1:0] ctrl;
    button_stat_t [BUTTON_COUNT-1:0] stat;

    logic              accept;
    logic [PIN_W-1:0]  pin_levels;
    logic [IDX_W-1:0]  button_index;
    logic [PIN_W-1:0]  rel_next, prs_next, hld_next;
    logic [BUTTON_COUNT-1:0] edge_hit;
    logic              edge_next;

    logic                 m_valid_reg;
    logic [PIN_W-1:0]     rel_reg, prs_reg, hld_reg;
    logic                 edge_reg;

    assign pin_levels   = s_tdata[PIN_W-1:0];
    assign button_index = s_tdata[PIN_W+IDX_W-1:PIN_W];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    bdhe_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_btn
        logic sel;
        assign sel = (button_index == IDX_W'(i));

        if (i < PIN_W) begin : g_pin
            assign ctrl[i].pin_high = pin_levels[i];
        end else begin : g_nopin
            // no pin bit in the field: seen as pressed
            assign ctrl[i].pin_high = 1'b0;
        end
        assign ctrl[i].tick     = accept && (s_tuser == KIND_TICK);
        assign ctrl[i].update   = accept && (s_tuser == KIND_UPDATE);
        assign ctrl[i].clr_rise = accept && (s_tuser == KIND_READ_RISE) && sel;
        assign ctrl[i].clr_fall = accept && (s_tuser == KIND_READ_FALL) && sel;

        assign edge_hit[i] = sel && (((s_tuser == KIND_READ_RISE) && stat[i].rise_open) ||
                                     ((s_tuser == KIND_READ_FALL) && stat[i].fall_open));

        bdhe_button u_button (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cfg     (cfg),
            .ctrl    (ctrl[i]),
            .stat    (stat[i])
        );
    end

    assign edge_next = |edge_hit;

    for (genvar j = 0; j < PIN_W; j++) begin : g_mask
        if (j < BUTTON_COUNT) begin : g_used
            always_comb begin
                rel_next[j] = 1'b0;
                prs_next[j] = 1'b0;
                hld_next[j] = 1'b0;
                unique case (stat[j].mode_next)
                    MODE_PRESSED: prs_next[j] = 1'b1;
                    MODE_HELD: begin
                        prs_next[j] = 1'b1;
                        hld_next[j] = 1'b1;
                    end
                    default: rel_next[j] = 1'b1;
                endcase
            end
        end else begin : g_unused
            assign rel_next[j] = 1'b0;
            assign prs_next[j] = 1'b0;
            assign hld_next[j] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rel_reg  <= rel_next;
            prs_reg  <= prs_next;
            hld_reg  <= hld_next;
            edge_reg <= edge_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - 3*PIN_W - 1){1'b0}}, edge_reg, hld_reg, prs_reg, rel_reg};

    // held buttons always count as pressed
    a_held_in_pressed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((hld_reg & ~prs_reg) == '0))
        else $error("held mask outside pressed mask");

    // no button is both released and pressed
    a_rel_prs_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((rel_reg & prs_reg) == '0))
        else $error("button both released and pressed");

    // tick and update transfers never report an edge
    a_edge_only_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_tuser == KIND_TICK || s_tuser == KIND_UPDATE)) |=> !edge_reg)
        else $error("edge reported for a non-read item");

    // a stalled result blocks the input side
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while result stalled");

endmodule
